// File: design/sunday_pattern_search_core_defines.svh
`ifndef SUNDAY_PATTERN_SEARCH_CORE_DEFINES_SVH
`define SUNDAY_PATTERN_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sps_pkg.sv
package sps_pkg;

	localparam int BYTE_W        = 8;
	localparam int OFFSET_W      = 12;
	localparam int SHIFT_W       = 7;
	localparam int SHIFT_ENTRIES = 'h100;
	localparam int SHIFT_AW      = $clog2(SHIFT_ENTRIES);

	// Load command codes
	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// Operand select for the shared position adder
	typedef enum logic [1:0] {
		ADD_J  = 2'd0,
		ADD_M  = 2'd1,
		ADD_SH = 2'd2
	} add_sel_t;

endpackage

// File: design/sps_load_if.sv
interface sps_load_if import sps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] data_byte;
	logic              last_flag;

	modport source (output valid, cmd, data_byte, last_flag, input ready);
	modport sink (input valid, cmd, data_byte, last_flag, output ready);
endinterface

// File: design/sps_result_if.sv
interface sps_result_if import sps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [OFFSET_W-1:0] match_offset;
	logic                overflow;

	modport source (output valid, found, match_offset, overflow, input ready);
	modport sink (input valid, found, match_offset, overflow, output ready);
endinterface

// File: design/sps_ram.sv
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/sunday_pattern_search_core.sv
// Pattern and text bytes load at one byte per cycle; ready is high whenever no search runs.
// A text byte with last_flag starts a search: a shift-table sweep and build, then byte compares
// and shifts, using the shared position adder and the registered RAM reads, then the report.
// An empty pattern or one longer than the text goes from the start state straight to report.
// Reset clears control state: pattern empty and closed, text length and overflow zero;
// RAM contents are kept and the shift table is rebuilt by a sweep of all 256 entries per scan.
`include "sunday_pattern_search_core_defines.svh"

module sunday_pattern_search_core import sps_pkg::*; #(
	parameter int PATTERN_DEPTH = 64,
	parameter int TEXT_DEPTH    = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	sps_load_if.sink       load,
	sps_result_if.source   result
);
	localparam int ML  = $clog2(PATTERN_DEPTH + 1);
	localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int TLW = $clog2(TEXT_DEPTH + 1);
	localparam int TAW = $clog2(TEXT_DEPTH);
	localparam int PW  = TLW + 8;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_START   = 4'd1;
	localparam logic [3:0] ST_CLR     = 4'd2;
	localparam logic [3:0] ST_BLD_RD  = 4'd3;
	localparam logic [3:0] ST_BLD_WR  = 4'd4;
	localparam logic [3:0] ST_CMP_RD  = 4'd5;
	localparam logic [3:0] ST_CMP_CHK = 4'd6;
	localparam logic [3:0] ST_SH_RD   = 4'd7;
	localparam logic [3:0] ST_SH_TBL  = 4'd8;
	localparam logic [3:0] ST_SH_ADD  = 4'd9;
	localparam logic [3:0] ST_POS_CHK = 4'd10;
	localparam logic [3:0] ST_REPORT  = 4'd11;

	logic [3:0]          state_q;
	logic [ML-1:0]       plen_q;
	logic                pclosed_q;
	logic [TLW-1:0]      tlen_q;
	logic                ovf_q;
	logic [ML-1:0]       j_q;
	logic [SHIFT_AW-1:0] idx_q;
	logic [PW-1:0]       pos_q;
	logic                hit_q;

	logic                out_valid_q;
	logic                out_found_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic                out_ovf_q;

	logic [BYTE_W-1:0]   pat_rd;
	logic [BYTE_W-1:0]   txt_rd;
	logic [SHIFT_W-1:0]  sh_rd;

	logic                accept;
	logic [ML-1:0]       pbase;
	logic                pat_we;
	logic                txt_we;
	logic                sh_we;
	logic [SHIFT_AW-1:0] sh_waddr;
	logic [SHIFT_W-1:0]  sh_wdata;
	logic [SHIFT_AW-1:0] sh_raddr;

	add_sel_t            add_sel;
	logic [PW-1:0]       add_b;
	logic [PW-1:0]       add_s;
	logic [PW-1:0]       n_ext;
	logic [PW-1:0]       m_ext;
	logic                out_free;
	logic                last_text;
	logic                sweep_end;
	logic                report_go;

	assign accept   = load.valid && load.ready;
	assign load.ready = (state_q == ST_IDLE);
	assign pbase    = pclosed_q ? '0 : plen_q;
	assign pat_we   = accept && load.cmd == CMD_PATTERN && (pbase < ML'(PATTERN_DEPTH));
	assign txt_we   = accept && load.cmd == CMD_TEXT && (tlen_q < TLW'(TEXT_DEPTH));
	assign n_ext    = PW'(tlen_q);
	assign m_ext    = PW'(plen_q);
	assign out_free = !out_valid_q || result.ready;
	assign last_text = accept && load.cmd == CMD_TEXT && load.last_flag;
	assign sweep_end = state_q == ST_CLR && idx_q == SHIFT_AW'(SHIFT_ENTRIES - 1);
	assign report_go = state_q == ST_REPORT && out_free;

	// Shared position adder: pos plus j, m or the looked-up shift
	always_comb begin
		case (state_q)
			ST_CMP_CHK, ST_SH_RD, ST_POS_CHK: add_sel = ADD_M;
			ST_SH_ADD:                        add_sel = ADD_SH;
			default:                          add_sel = ADD_J;
		endcase
		case (add_sel)
			ADD_M:   add_b = m_ext;
			ADD_SH:  add_b = PW'(sh_rd);
			default: add_b = PW'(j_q);
		endcase
		add_s = pos_q + add_b;
	end

	always_comb begin
		sh_we    = 1'b0;
		sh_waddr = idx_q;
		sh_wdata = SHIFT_W'(plen_q) + SHIFT_W'(1);
		if (state_q == ST_CLR) begin
			sh_we = 1'b1;
		end else if (state_q == ST_BLD_WR) begin
			sh_we    = 1'b1;
			sh_waddr = pat_rd;
			sh_wdata = SHIFT_W'(plen_q - j_q);
		end
	end

	assign sh_raddr = txt_rd;

	sps_ram #(.WIDTH(BYTE_W), .DEPTH(PATTERN_DEPTH)) u_pattern_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pbase[PAW-1:0]),
		.wdata (load.data_byte),
		.raddr (j_q[PAW-1:0]),
		.rdata (pat_rd)
	);

	sps_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
		.clk   (clk),
		.we    (txt_we),
		.waddr (tlen_q[TAW-1:0]),
		.wdata (load.data_byte),
		.raddr (add_s[TAW-1:0]),
		.rdata (txt_rd)
	);

	sps_ram #(.WIDTH(SHIFT_W), .DEPTH(SHIFT_ENTRIES)) u_shift_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata),
		.raddr (sh_raddr),
		.rdata (sh_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plen_q      <= '0;
			pclosed_q   <= 1'b1;
			tlen_q      <= '0;
			ovf_q       <= 1'b0;
			j_q         <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready && !report_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && load.cmd == CMD_PATTERN) begin
						plen_q    <= pat_we ? pbase + ML'(1) : pbase;
						pclosed_q <= load.last_flag;
						if (!pat_we) begin
							ovf_q <= 1'b1;
						end
					end else if (accept) begin
						if (txt_we) begin
							tlen_q <= tlen_q + TLW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (load.last_flag) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					hit_q <= 1'b0;
					pos_q <= '0;
					j_q   <= '0;
					idx_q <= '0;
					if (plen_q == '0 || m_ext > n_ext) begin
						state_q <= ST_REPORT;
					end else begin
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					idx_q <= idx_q + SHIFT_AW'(1);
					if (sweep_end) begin
						state_q <= ST_BLD_RD;
					end
				end
				ST_BLD_RD: begin
					state_q <= ST_BLD_WR;
				end
				ST_BLD_WR: begin
					if (j_q + ML'(1) == plen_q) begin
						j_q     <= '0;
						state_q <= ST_CMP_RD;
					end else begin
						j_q     <= j_q + ML'(1);
						state_q <= ST_BLD_RD;
					end
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_CHK;
				end
				ST_CMP_CHK: begin
					if (txt_rd == pat_rd) begin
						if (j_q + ML'(1) == plen_q) begin
							hit_q   <= 1'b1;
							state_q <= ST_REPORT;
						end else begin
							j_q     <= j_q + ML'(1);
							state_q <= ST_CMP_RD;
						end
					end else if (add_s >= n_ext) begin
						state_q <= ST_REPORT;
					end else begin
						state_q <= ST_SH_RD;
					end
				end
				ST_SH_RD: begin
					state_q <= ST_SH_TBL;
				end
				ST_SH_TBL: begin
					state_q <= ST_SH_ADD;
				end
				ST_SH_ADD: begin
					pos_q   <= add_s;
					j_q     <= '0;
					state_q <= ST_POS_CHK;
				end
				ST_POS_CHK: begin
					state_q <= (add_s <= n_ext) ? ST_CMP_RD : ST_REPORT;
				end
				ST_REPORT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tlen_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload: load on the report cycle, hold otherwise
	always_ff @(posedge clk) begin
		if (report_go) begin
			out_found_q  <= hit_q;
			out_offset_q <= hit_q ? pos_q[OFFSET_W-1:0] : '0;
			out_ovf_q    <= ovf_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = out_found_q;
	assign result.match_offset = out_offset_q;
	assign result.overflow     = out_ovf_q;

	`SPS_ASSERT_NEXT(a_last_text_starts, last_text, state_q == ST_START, "no search start")
	`SPS_ASSERT_NEXT(a_clear_to_build, sweep_end, state_q == ST_BLD_RD, "sweep did not end")
	`SPS_ASSERT_NEXT(a_report_clears, report_go, out_valid_q && tlen_q == '0 && !ovf_q, "no post")
	`SPS_ASSERT_NOW(a_miss_offset_zero, out_valid_q && !out_found_q, out_offset_q == '0, "bad offset")
	`SPS_ASSERT_NOW(a_plen_bound, 1'b1, plen_q <= ML'(PATTERN_DEPTH), "pattern too long")

endmodule

// File: sim/tb_sunday_pattern_search_core.sv
module tb_sunday_pattern_search_core import sps_pkg::*; ();

	localparam int PATTERN_DEPTH = 64;
	localparam int TEXT_DEPTH    = 4096;

	localparam int IDLE_PCT     = 34;
	localparam int ITEM_TARGET  = 1050;
	localparam int LONG_LEN     = 200;
	localparam int STALL_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
		logic                overflow;
	} search_result_t;

	class search_scoreboard;
		logic [BYTE_W-1:0] pat_mem[PATTERN_DEPTH];
		int unsigned       pat_len;
		bit                pat_closed;
		logic [BYTE_W-1:0] text_mem[TEXT_DEPTH];
		int unsigned       text_len;
		bit                dropped;
		search_result_t    pending[$];
		int unsigned       errors;

		function new();
			pat_len    = 0;
			pat_closed = 1'b1;
			text_len   = 0;
			dropped    = 1'b0;
			errors     = 0;
		endfunction

		function void note_load(logic cmd, logic [BYTE_W-1:0] data, logic last);
			logic [SHIFT_W-1:0] shift_by[SHIFT_ENTRIES];
			search_result_t     hit;
			int unsigned        pos;
			int unsigned        j;
			bit                 done;
			if (cmd == CMD_PATTERN) begin
				// a byte after a closed pattern starts a fresh one
				if (pat_closed) begin
					pat_len    = 0;
					pat_closed = 1'b0;
				end
				if (pat_len < PATTERN_DEPTH) begin
					pat_mem[pat_len] = data;
					pat_len++;
				end else begin
					dropped = 1'b1;
				end
				if (last)
					pat_closed = 1'b1;
			end else begin
				if (text_len < TEXT_DEPTH) begin
					text_mem[text_len] = data;
					text_len++;
				end else begin
					dropped = 1'b1;
				end
				if (last) begin
					hit = '0;
					hit.overflow = dropped;
					if (pat_len != 0 && pat_len <= text_len) begin
						for (int k = 0; k < SHIFT_ENTRIES; k++)
							shift_by[k] = SHIFT_W'(pat_len + 1);
						for (int k = 0; k < pat_len; k++)
							shift_by[pat_mem[k]] = SHIFT_W'(pat_len - k);
						pos  = 0;
						done = 1'b0;
						// walk the alignments by Sunday shifts, the one ending on the last byte too
						while (!done && pos + pat_len <= text_len) begin
							j = 0;
							while (j < pat_len && text_mem[pos + j] == pat_mem[j])
								j++;
							if (j == pat_len) begin
								hit.found        = 1'b1;
								hit.match_offset = OFFSET_W'(pos);
								done             = 1'b1;
							end else if (pos + pat_len >= text_len) begin
								done = 1'b1;
							end else begin
								pos += shift_by[text_mem[pos + pat_len]];
							end
						end
					end
					pending.insert(pending.size(), hit);
					text_len = 0;
					dropped  = 1'b0;
				end
			end
		endfunction

		function void check_result(search_result_t got);
			search_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: stray result: expected none, actual found=%0b offset=%0d ovf=%0b",
					$time, got.found, got.match_offset, got.overflow);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.found !== want.found) begin
					$display("%0t: found mismatch: expected %0b, actual %0b",
						$time, want.found, got.found);
					errors++;
				end
				if (got.match_offset !== want.match_offset) begin
					$display("%0t: match_offset mismatch: expected %0d, actual %0d",
						$time, want.match_offset, got.match_offset);
					errors++;
				end
				if (got.overflow !== want.overflow) begin
					$display("%0t: overflow mismatch: expected %0b, actual %0b",
						$time, want.overflow, got.overflow);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sps_load_if   load_bus();
	sps_result_if result_bus();

	sunday_pattern_search_core #(
		.PATTERN_DEPTH(PATTERN_DEPTH),
		.TEXT_DEPTH   (TEXT_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load_bus),
		.result(result_bus)
	);

	search_scoreboard  book = new();
	bit                steady = 1'b0;
	int unsigned       items_sent = 0;
	logic [BYTE_W-1:0] alpha[3];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] next_byte(bit narrow);
		if (narrow)
			return alpha[$urandom_range(0, 2)];
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic drive_byte(logic cmd, logic [BYTE_W-1:0] data, logic last);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			load_bus.valid <= 1'b0;
			@(posedge clk);
		end
		load_bus.valid     <= 1'b1;
		load_bus.cmd       <= cmd;
		load_bus.data_byte <= data;
		load_bus.last_flag <= last;
		@(posedge clk);
		while (!load_bus.ready)
			@(posedge clk);
		book.note_load(cmd, data, last);
		items_sent++;
	endtask

	task automatic send_pattern(int unsigned len, bit narrow);
		for (int i = 0; i < 3; i++)
			alpha[i] = BYTE_W'($urandom_range(0, 255));
		for (int unsigned i = 0; i < len; i++)
			drive_byte(CMD_PATTERN, next_byte(narrow), i == len - 1);
	endtask

	task automatic send_text(int unsigned len, bit narrow, bit plant);
		logic [BYTE_W-1:0] body[];
		int unsigned       at;
		body = new[len];
		for (int unsigned i = 0; i < len; i++)
			body[i] = next_byte(narrow);
		// drop the current pattern somewhere in the block to get hits
		if (plant && book.pat_len != 0 && book.pat_len <= len) begin
			at = $urandom_range(0, len - book.pat_len);
			for (int unsigned k = 0; k < book.pat_len; k++)
				body[at + k] = book.pat_mem[k];
		end
		for (int unsigned i = 0; i < len; i++)
			drive_byte(CMD_TEXT, body[i], i == len - 1);
	endtask

	initial begin
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready)
				book.check_result({result_bus.found, result_bus.match_offset,
					result_bus.overflow});
			result_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (load_bus.valid && load_bus.ready) ||
					(result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned       block;
		int unsigned       roll;
		int unsigned       waited;
		logic [BYTE_W-1:0] b;

		arst_n             <= 1'b0;
		load_bus.valid     <= 1'b0;
		load_bus.cmd       <= CMD_PATTERN;
		load_bus.data_byte <= '0;
		load_bus.last_flag <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern right after reset
		drive_byte(CMD_TEXT, 8'h41, 1'b1);
		// pattern of the extreme byte values, hit on the final alignment
		drive_byte(CMD_PATTERN, 8'h00, 1'b0);
		drive_byte(CMD_PATTERN, 8'hFF, 1'b1);
		drive_byte(CMD_TEXT, 8'hFF, 1'b0);
		drive_byte(CMD_TEXT, 8'h00, 1'b0);
		drive_byte(CMD_TEXT, 8'hFF, 1'b1);
		// hit at offset zero, pattern kept across blocks
		drive_byte(CMD_TEXT, 8'h00, 1'b0);
		drive_byte(CMD_TEXT, 8'hFF, 1'b1);
		// pattern longer than the text
		drive_byte(CMD_TEXT, 8'h00, 1'b1);
		// no occurrence
		drive_byte(CMD_TEXT, 8'h12, 1'b0);
		drive_byte(CMD_TEXT, 8'h34, 1'b0);
		drive_byte(CMD_TEXT, 8'h56, 1'b1);
		// text while the pattern is still open, then append to it
		drive_byte(CMD_PATTERN, 8'hAA, 1'b0);
		drive_byte(CMD_TEXT, 8'h55, 1'b0);
		drive_byte(CMD_TEXT, 8'hAA, 1'b1);
		drive_byte(CMD_PATTERN, 8'hBB, 1'b1);
		drive_byte(CMD_TEXT, 8'hAA, 1'b0);
		drive_byte(CMD_TEXT, 8'hBB, 1'b1);

		block = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = (block >= 30 && block < 50);
			roll   = $urandom_range(0, 99);
			if (block == 3) begin
				send_pattern($urandom_range(PATTERN_DEPTH + 1, PATTERN_DEPTH + 4), 1'b1);
			end else if (block == 5) begin
				send_pattern(PATTERN_DEPTH, 1'b1);
			end else if (block == 40) begin
				// one-byte pattern found only on the final alignment of a long block
				drive_byte(CMD_PATTERN, 8'hC3, 1'b1);
				for (int i = 0; i < LONG_LEN; i++) begin
					b = BYTE_W'($urandom_range(0, 254));
					if (b >= 8'hC3)
						b++;
					if (i == LONG_LEN - 1)
						b = 8'hC3;
					drive_byte(CMD_TEXT, b, i == LONG_LEN - 1);
				end
			end else if (roll < 14) begin
				send_pattern(roll < 2 ? $urandom_range(7, PATTERN_DEPTH) : $urandom_range(1, 6),
					$urandom_range(0, 3) != 0);
			end else if (roll < 19) begin
				// stray transactions of any kind
				repeat ($urandom_range(1, 3))
					drive_byte(logic'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
						logic'($urandom_range(0, 1)));
			end else begin
				send_text(roll < 24 ? $urandom_range(40, 120) : $urandom_range(1, 24),
					roll % 3 != 0, roll % 4 != 0);
			end
			block++;
		end
		load_bus.valid <= 1'b0;

		waited = 0;
		while (book.pending.size() != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.pending.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, book.pending.size());
			book.errors++;
		end
		if (book.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/sps_pkg.sv
design/sps_load_if.sv
design/sps_result_if.sv
design/sps_ram.sv
design/sunday_pattern_search_core.sv
sim/tb_sunday_pattern_search_core.sv
